[rtl/mgmt_pkg.sv]
// Package for the multicast group membership table: request modes, status codes,
// register indexes, constants, the request/response structs and a group check.
// No dependencies.
package mgmt_pkg;

	localparam int TABLE_ENTRIES_DEF = 4;

	localparam int GRP_W     = 32;
	localparam int IFA_W     = 32;
	localparam int COUNT_W   = 16;
	localparam int SLOT_OUT_W = 2;
	localparam int MAC_W     = 48;
	localparam int LINK_W    = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 56;

	localparam logic [3:0]        CLASS_D_NIBBLE  = 4'hE;
	localparam logic [GRP_W-1:0]  ALL_HOSTS_GROUP = 32'hE000_0001;
	localparam logic [23:0]       MAC_PREFIX      = 24'h01_005E;
	localparam logic [LINK_W-1:0] LINK_FILTER_LIM = 4'd5;
	localparam logic [COUNT_W-1:0] COUNT_MAX      = 16'hFFFF;
	localparam logic [COUNT_W-1:0] COUNT_ONE      = 16'd1;

	typedef enum logic [1:0] {
		MODE_JOIN   = 2'd0,
		MODE_LEAVE  = 2'd1,
		MODE_LOOKUP = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_MCAST = 3'd1,
		ST_ALL_HOSTS = 3'd2,
		ST_FULL      = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EMPTY_MARKER = 1'd0,
		REG_LINK_TYPE    = 1'd1
	} cfg_reg_t;

	typedef struct packed {
		logic             en;
		mode_t            mode;
		logic [GRP_W-1:0] grp;
		logic [IFA_W-1:0] ifa;
	} tbl_req_t;

	typedef struct packed {
		status_t               status;
		logic [SLOT_OUT_W-1:0] slot;
		logic                  new_entry;
	} tbl_resp_t;

	function automatic status_t check_group(input logic [GRP_W-1:0] grp);
		status_t st;
		if (grp[GRP_W-1 -: 4] != CLASS_D_NIBBLE) begin
			st = ST_NOT_MCAST;
		end else if (grp == ALL_HOSTS_GROUP) begin
			st = ST_ALL_HOSTS;
		end else begin
			st = ST_OK;
		end
		return st;
	endfunction

endpackage

[rtl/mgmt_table.sv]
// Membership table storage with parallel match, free-slot search and update.
// Depends on mgmt_pkg.
module mgmt_table #(
	parameter int TABLE_ENTRIES = mgmt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mgmt_pkg::tbl_req_t             req,
	input  logic [mgmt_pkg::GRP_W-1:0]     empty_marker,
	output mgmt_pkg::tbl_resp_t            resp
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	logic [mgmt_pkg::GRP_W-1:0]   group_q [TABLE_ENTRIES];
	logic [mgmt_pkg::IFA_W-1:0]   iface_q [TABLE_ENTRIES];
	logic [mgmt_pkg::COUNT_W-1:0] count_q [TABLE_ENTRIES];

	logic [mgmt_pkg::GRP_W-1:0]   group_d [TABLE_ENTRIES];
	logic [mgmt_pkg::IFA_W-1:0]   iface_d [TABLE_ENTRIES];
	logic [mgmt_pkg::COUNT_W-1:0] count_d [TABLE_ENTRIES];

	logic [TABLE_ENTRIES-1:0] hit_vec;
	logic [TABLE_ENTRIES-1:0] free_vec;
	logic [IDX_W-1:0]         hit_idx;
	logic [IDX_W-1:0]         free_idx;
	mgmt_pkg::status_t        grp_status;

	// Match and free search over all slots; the lowest set slot wins.
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			hit_vec[i]  = (group_q[i] == req.grp) && (iface_q[i] == req.ifa);
			free_vec[i] = (group_q[i] == empty_marker);
		end
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (free_vec[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	assign grp_status = mgmt_pkg::check_group(req.grp);

	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			group_d[i] = group_q[i];
			iface_d[i] = iface_q[i];
			count_d[i] = count_q[i];
		end
		resp.status    = mgmt_pkg::ST_OK;
		resp.slot      = '0;
		resp.new_entry = 1'b0;

		if (req.mode == mgmt_pkg::MODE_CLEAR) begin
			// Only the group words are rewritten; interfaces and counts stay.
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				group_d[i] = empty_marker;
			end
		end else if (grp_status != mgmt_pkg::ST_OK) begin
			resp.status = grp_status;
		end else if (req.mode == mgmt_pkg::MODE_JOIN) begin
			if (|hit_vec) begin
				if (count_q[hit_idx] != mgmt_pkg::COUNT_MAX) begin
					count_d[hit_idx] = count_q[hit_idx] + mgmt_pkg::COUNT_ONE;
				end
				resp.slot = mgmt_pkg::SLOT_OUT_W'(hit_idx);
			end else if (|free_vec) begin
				group_d[free_idx] = req.grp;
				iface_d[free_idx] = req.ifa;
				count_d[free_idx] = mgmt_pkg::COUNT_ONE;
				resp.slot         = mgmt_pkg::SLOT_OUT_W'(free_idx);
				resp.new_entry    = 1'b1;
			end else begin
				resp.status = mgmt_pkg::ST_FULL;
			end
		end else if (!(|hit_vec)) begin
			resp.status = mgmt_pkg::ST_NOT_FOUND;
		end else begin
			resp.slot = mgmt_pkg::SLOT_OUT_W'(hit_idx);
			if (req.mode == mgmt_pkg::MODE_LEAVE) begin
				if (count_q[hit_idx] <= mgmt_pkg::COUNT_ONE) begin
					count_d[hit_idx] = '0;
					group_d[hit_idx] = empty_marker;
				end else begin
					count_d[hit_idx] = count_q[hit_idx] - mgmt_pkg::COUNT_ONE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				group_q[i] <= '0;
				iface_q[i] <= '0;
				count_q[i] <= '0;
			end
		end else if (req.en) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				group_q[i] <= group_d[i];
				iface_q[i] <= iface_d[i];
				count_q[i] <= count_d[i];
			end
		end
	end

endmodule

[rtl/multicast_group_membership_table_unit.sv]
// Top level of the multicast group membership table: stream ports, input and
// result registers, configuration registers. Depends on mgmt_pkg, mgmt_table.
//
//   channel   direction  handshake            payload
//   s_*       in         s_tvalid / s_tready  request word (mode, group, interface)
//   m_*       out        m_tvalid / m_tready  result word (status, slot, requests, MAC)
//   cfg_*     in         cfg_valid/cfg_ready  register index and write data
//
// A request word is held in the input register; the table lookup and
// update run in the cycle it moves to the result register, so one word per
// cycle passes when m_tready stays high. The table is written at the same edge
// that loads the result register, so the next request sees the update.
// A stall on m_* holds both registers; reset empties the table at once.
module multicast_group_membership_table_unit #(
	parameter int TABLE_ENTRIES = mgmt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [1:0] mode, [33:2] group_address, [65:34] interface_address, rest zero
	input  logic [mgmt_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [2:0] status, [4:3] slot, [5] report_request, [6] filter_request,
	// [54:7] filter_mac, [55] zero
	output logic [mgmt_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mgmt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mgmt_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic                          valid_s1;
	mgmt_pkg::mode_t               mode_s1;
	logic [mgmt_pkg::GRP_W-1:0]    grp_s1;
	logic [mgmt_pkg::IFA_W-1:0]    ifa_s1;

	logic                          valid_s2;
	logic [mgmt_pkg::OUT_DATA_W-1:0] data_s2;

	logic [mgmt_pkg::GRP_W-1:0]    empty_marker_q;
	logic [mgmt_pkg::LINK_W-1:0]   link_type_q;

	logic                          advance;
	mgmt_pkg::tbl_req_t            tbl_req;
	mgmt_pkg::tbl_resp_t           tbl_resp;
	logic                          report_req;
	logic                          filter_req;
	logic [mgmt_pkg::MAC_W-1:0]    filter_mac;

	assign advance   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1 <= mgmt_pkg::mode_t'(s_tdata[1:0]);
			grp_s1  <= s_tdata[33:2];
			ifa_s1  <= s_tdata[65:34];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_marker_q <= '0;
			link_type_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mgmt_pkg::REG_EMPTY_MARKER: empty_marker_q <= cfg_data;
				mgmt_pkg::REG_LINK_TYPE:    link_type_q <= cfg_data[mgmt_pkg::LINK_W-1:0];
				default: ;
			endcase
		end
	end

	assign tbl_req.en   = advance;
	assign tbl_req.mode = mode_s1;
	assign tbl_req.grp  = grp_s1;
	assign tbl_req.ifa  = ifa_s1;

	mgmt_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_table (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (tbl_req),
		.empty_marker (empty_marker_q),
		.resp         (tbl_resp)
	);

	// A new entry whose group equals the empty marker reads back as free,
	// so no report goes out for it.
	assign report_req = tbl_resp.new_entry && (grp_s1 != empty_marker_q);
	assign filter_req = tbl_resp.new_entry && (link_type_q < mgmt_pkg::LINK_FILTER_LIM);
	assign filter_mac = tbl_resp.new_entry
		? {mgmt_pkg::MAC_PREFIX, 1'b0, grp_s1[22:0]} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= {1'b0, filter_mac, filter_req, report_req, tbl_resp.slot,
				tbl_resp.status};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

endmodule

[sim/multicast_group_membership_table_unit_tb.sv]
`timescale 1ns / 100ps
// Testbench for multicast_group_membership_table_unit: a directed table and randomized
// phases, checked against a local table model or, for typed rows, fixed expected results.
// Depends on mgmt_pkg and the unit RTL.
module multicast_group_membership_table_unit_tb;

	localparam int SLOTS = mgmt_pkg::TABLE_ENTRIES_DEF;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 190;
	localparam int SHOWN_MISMATCHES = 10;

	typedef struct packed {
		mgmt_pkg::status_t               status;
		logic [mgmt_pkg::SLOT_OUT_W-1:0] slot;
		logic                            report;
		logic                            filter;
		logic [mgmt_pkg::MAC_W-1:0]      mac;
	} member_result_t;

	typedef struct {
		bit                         is_cfg;
		bit                         typed;
		mgmt_pkg::cfg_reg_t         reg_idx;
		mgmt_pkg::mode_t            mode;
		logic [mgmt_pkg::GRP_W-1:0] grp;
		logic [mgmt_pkg::IFA_W-1:0] ifa;
		member_result_t             res;
	} stim_row_t;

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [mgmt_pkg::IN_DATA_W-1:0]  s_tdata;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [mgmt_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [mgmt_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [mgmt_pkg::CFG_DATA_W-1:0] cfg_data;

	// Local copy of the membership table and its registers.
	logic [mgmt_pkg::GRP_W-1:0]   group_tbl [SLOTS];
	logic [mgmt_pkg::IFA_W-1:0]   iface_tbl [SLOTS];
	logic [mgmt_pkg::COUNT_W-1:0] count_tbl [SLOTS];
	logic [mgmt_pkg::GRP_W-1:0]   empty_mark;
	logic [mgmt_pkg::LINK_W-1:0]  link_kind;

	member_result_t result_q[$];
	int mismatches = 0;
	int checked = 0;
	int accepted = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_go = 0;
	int hold_left = 0;
	int quiet = 0;

	multicast_group_membership_table_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one request to the local table and returns the result it yields.
	function automatic member_result_t apply_request(input mgmt_pkg::mode_t md,
			input logic [mgmt_pkg::GRP_W-1:0] g, input logic [mgmt_pkg::IFA_W-1:0] ifa);
		member_result_t r;
		int hit;
		int vacant;
		r = '0;
		r.status = mgmt_pkg::ST_OK;
		hit = -1;
		vacant = -1;
		if (md == mgmt_pkg::MODE_CLEAR) begin
			for (int k = 0; k < SLOTS; k++)
				group_tbl[k] = empty_mark;
		end else if (g[mgmt_pkg::GRP_W-1 -: 4] != mgmt_pkg::CLASS_D_NIBBLE) begin
			r.status = mgmt_pkg::ST_NOT_MCAST;
		end else if (g == mgmt_pkg::ALL_HOSTS_GROUP) begin
			r.status = mgmt_pkg::ST_ALL_HOSTS;
		end else begin
			// Walk downward so the lowest matching and lowest free slot win.
			for (int k = SLOTS - 1; k >= 0; k--) begin
				if (group_tbl[k] == g && iface_tbl[k] == ifa)
					hit = k;
				if (group_tbl[k] == empty_mark)
					vacant = k;
			end
			if (hit >= 0) begin
				r.slot = hit[mgmt_pkg::SLOT_OUT_W-1:0];
				if (md == mgmt_pkg::MODE_JOIN) begin
					if (count_tbl[hit] != mgmt_pkg::COUNT_MAX)
						count_tbl[hit] = count_tbl[hit] + mgmt_pkg::COUNT_ONE;
				end else if (md == mgmt_pkg::MODE_LEAVE) begin
					if (count_tbl[hit] <= mgmt_pkg::COUNT_ONE) begin
						count_tbl[hit] = '0;
						group_tbl[hit] = empty_mark;
					end else begin
						count_tbl[hit] = count_tbl[hit] - mgmt_pkg::COUNT_ONE;
					end
				end
			end else if (md != mgmt_pkg::MODE_JOIN) begin
				r.status = mgmt_pkg::ST_NOT_FOUND;
			end else if (vacant < 0) begin
				r.status = mgmt_pkg::ST_FULL;
			end else begin
				group_tbl[vacant] = g;
				iface_tbl[vacant] = ifa;
				count_tbl[vacant] = mgmt_pkg::COUNT_ONE;
				r.slot = vacant[mgmt_pkg::SLOT_OUT_W-1:0];
				r.mac = {mgmt_pkg::MAC_PREFIX, 1'b0, g[22:0]};
				r.filter = (link_kind < mgmt_pkg::LINK_FILTER_LIM);
				r.report = (g != empty_mark);
			end
		end
		return r;
	endfunction

	function automatic stim_row_t req_row(input mgmt_pkg::mode_t md,
			input logic [mgmt_pkg::GRP_W-1:0] g, input logic [mgmt_pkg::IFA_W-1:0] ifa);
		stim_row_t row;
		row.is_cfg = 1'b0;
		row.typed = 1'b0;
		row.reg_idx = mgmt_pkg::REG_EMPTY_MARKER;
		row.mode = md;
		row.grp = g;
		row.ifa = ifa;
		row.res = '0;
		return row;
	endfunction

	function automatic stim_row_t typed_row(input mgmt_pkg::mode_t md,
			input logic [mgmt_pkg::GRP_W-1:0] g, input logic [mgmt_pkg::IFA_W-1:0] ifa,
			input mgmt_pkg::status_t st, input logic [1:0] sl,
			input logic rp, input logic fl, input logic [mgmt_pkg::MAC_W-1:0] mac);
		stim_row_t row;
		row = req_row(md, g, ifa);
		row.typed = 1'b1;
		row.res.status = st;
		row.res.slot = sl;
		row.res.report = rp;
		row.res.filter = fl;
		row.res.mac = mac;
		return row;
	endfunction

	function automatic stim_row_t cfg_row(input mgmt_pkg::cfg_reg_t idx,
			input logic [mgmt_pkg::CFG_DATA_W-1:0] data);
		stim_row_t row;
		row = req_row(mgmt_pkg::MODE_CLEAR, data, '0);
		row.is_cfg = 1'b1;
		row.reg_idx = idx;
		return row;
	endfunction

	function automatic logic [mgmt_pkg::GRP_W-1:0] pick_group();
		logic [mgmt_pkg::GRP_W-1:0] pool [6];
		int roll;
		pool = '{32'hE000_0010, 32'hE000_0011, 32'hEF7F_FFFF, 32'hE080_0000,
			32'hE000_0001, 32'h0000_0000};
		pool[5] = empty_mark;
		roll = $urandom_range(99);
		if (roll < 8)
			return $urandom;
		if (roll < 16)
			return {mgmt_pkg::CLASS_D_NIBBLE, 28'($urandom)};
		return pool[$urandom_range(5)];
	endfunction

	function automatic logic [mgmt_pkg::IFA_W-1:0] pick_iface();
		logic [mgmt_pkg::IFA_W-1:0] pool [3];
		pool = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF};
		if ($urandom_range(99) < 15)
			return $urandom;
		return pool[$urandom_range(2)];
	endfunction

	// Offers one request word, waits for it to be taken, then records its result.
	task automatic issue(input mgmt_pkg::mode_t md, input logic [mgmt_pkg::GRP_W-1:0] g,
			input logic [mgmt_pkg::IFA_W-1:0] ifa, input bit use_typed,
			input member_result_t typed_res);
		member_result_t r;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, ifa, g, md};
		do @(posedge clk); while (!s_tready);
		r = apply_request(md, g, ifa);
		result_q.push_back(use_typed ? typed_res : r);
		accepted++;
	endtask

	task automatic cfg_write(input mgmt_pkg::cfg_reg_t idx,
			input logic [mgmt_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == mgmt_pkg::REG_EMPTY_MARKER)
			empty_mark = data;
		else
			link_kind = data[mgmt_pkg::LINK_W-1:0];
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stops offering words and waits until every pending result is out.
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (result_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		member_result_t got;
		member_result_t want;
		got.status = mgmt_pkg::status_t'(m_tdata[2:0]);
		got.slot = m_tdata[4:3];
		got.report = m_tdata[5];
		got.filter = m_tdata[6];
		got.mac = m_tdata[54:7];
		if (arst_n && m_tvalid && m_tready) begin
			if (result_q.size() == 0) begin
				if (mismatches < SHOWN_MISMATCHES)
					$display("unexpected result word at %0t: %h", $time, m_tdata);
				mismatches++;
			end else begin
				want = result_q.pop_front();
				checked++;
				if (got.status !== want.status || got.slot !== want.slot ||
						got.report !== want.report || got.filter !== want.filter ||
						got.mac !== want.mac) begin
					if (mismatches < SHOWN_MISMATCHES) begin
						$display("mismatch at %0t: expected st=%0d slot=%0d rep=%b flt=%b mac=%h",
							$time, want.status, want.slot, want.report, want.filter, want.mac);
						$display("                  got      st=%0d slot=%0d rep=%b flt=%b mac=%h",
							got.status, got.slot, got.report, got.filter, got.mac);
					end
					mismatches++;
				end
			end
		end
		// A long hold-off lets the pipeline fill and push back on the input.
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (hold_go != 0) begin
			hold_go = 0;
			hold_left = HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t plan[$];
		mgmt_pkg::mode_t md;
		int roll;
		logic [mgmt_pkg::GRP_W-1:0] phase_em [PHASES];
		logic [mgmt_pkg::LINK_W-1:0] phase_lt [PHASES];
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = mgmt_pkg::REG_EMPTY_MARKER;
		cfg_data = '0;
		empty_mark = '0;
		link_kind = '0;
		for (int k = 0; k < SLOTS; k++) begin
			group_tbl[k] = '0;
			iface_tbl[k] = '0;
			count_tbl[k] = '0;
		end

		// Reset register values: empty marker zero, link type zero.
		plan.push_back(typed_row(mgmt_pkg::MODE_LOOKUP, 32'hE000_0002, 32'h0,
			mgmt_pkg::ST_NOT_FOUND, 2'd0, 1'b0, 1'b0, 48'h0));
		plan.push_back(typed_row(mgmt_pkg::MODE_JOIN, 32'h0000_0000, 32'h0,
			mgmt_pkg::ST_NOT_MCAST, 2'd0, 1'b0, 1'b0, 48'h0));
		plan.push_back(typed_row(mgmt_pkg::MODE_JOIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			mgmt_pkg::ST_NOT_MCAST, 2'd0, 1'b0, 1'b0, 48'h0));
		plan.push_back(typed_row(mgmt_pkg::MODE_JOIN, 32'hE000_0001, 32'h0,
			mgmt_pkg::ST_ALL_HOSTS, 2'd0, 1'b0, 1'b0, 48'h0));
		plan.push_back(typed_row(mgmt_pkg::MODE_LEAVE, 32'hEFFF_FFFF, 32'hFFFF_FFFF,
			mgmt_pkg::ST_NOT_FOUND, 2'd0, 1'b0, 1'b0, 48'h0));
		plan.push_back(typed_row(mgmt_pkg::MODE_JOIN, 32'hEFFF_FFFF, 32'hFFFF_FFFF,
			mgmt_pkg::ST_OK, 2'd0, 1'b1, 1'b1, 48'h0100_5E7F_FFFF));
		plan.push_back(req_row(mgmt_pkg::MODE_JOIN, 32'hEFFF_FFFF, 32'hFFFF_FFFF));
		plan.push_back(typed_row(mgmt_pkg::MODE_JOIN, 32'hE000_0000, 32'h0,
			mgmt_pkg::ST_OK, 2'd1, 1'b1, 1'b1, 48'h0100_5E00_0000));
		plan.push_back(req_row(mgmt_pkg::MODE_JOIN, 32'hE123_4567, 32'h1234_5678));
		plan.push_back(req_row(mgmt_pkg::MODE_JOIN, 32'hEF00_0002, 32'h0000_0001));
		plan.push_back(typed_row(mgmt_pkg::MODE_JOIN, 32'hE000_0005, 32'h0000_0002,
			mgmt_pkg::ST_FULL, 2'd0, 1'b0, 1'b0, 48'h0));
		plan.push_back(req_row(mgmt_pkg::MODE_LOOKUP, 32'hE123_4567, 32'h1234_5678));
		plan.push_back(req_row(mgmt_pkg::MODE_LEAVE, 32'hEFFF_FFFF, 32'hFFFF_FFFF));
		plan.push_back(req_row(mgmt_pkg::MODE_LEAVE, 32'hEFFF_FFFF, 32'hFFFF_FFFF));
		plan.push_back(typed_row(mgmt_pkg::MODE_LEAVE, 32'hEFFF_FFFF, 32'hFFFF_FFFF,
			mgmt_pkg::ST_NOT_FOUND, 2'd0, 1'b0, 1'b0, 48'h0));
		plan.push_back(typed_row(mgmt_pkg::MODE_LOOKUP, 32'hDFFF_FFFF, 32'h0,
			mgmt_pkg::ST_NOT_MCAST, 2'd0, 1'b0, 1'b0, 48'h0));
		plan.push_back(typed_row(mgmt_pkg::MODE_LEAVE, 32'hE000_0001, 32'h0,
			mgmt_pkg::ST_ALL_HOSTS, 2'd0, 1'b0, 1'b0, 48'h0));
		plan.push_back(typed_row(mgmt_pkg::MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			mgmt_pkg::ST_OK, 2'd0, 1'b0, 1'b0, 48'h0));
		// A class D empty marker: new slots holding it raise no report, and free
		// slots still match on group and interface.
		plan.push_back(cfg_row(mgmt_pkg::REG_EMPTY_MARKER, 32'hE000_0010));
		plan.push_back(cfg_row(mgmt_pkg::REG_LINK_TYPE, 32'd5));
		plan.push_back(req_row(mgmt_pkg::MODE_CLEAR, 32'h0, 32'h0));
		plan.push_back(req_row(mgmt_pkg::MODE_JOIN, 32'hE000_0010, 32'h0000_0007));
		plan.push_back(req_row(mgmt_pkg::MODE_JOIN, 32'hE000_0010, 32'h0000_0007));
		plan.push_back(req_row(mgmt_pkg::MODE_LOOKUP, 32'hE000_0010, 32'h0000_0000));
		plan.push_back(req_row(mgmt_pkg::MODE_LEAVE, 32'hE000_0010, 32'h0000_0007));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k]) begin
			if (plan[k].is_cfg) begin
				settle();
				cfg_write(plan[k].reg_idx, plan[k].grp);
			end else begin
				issue(plan[k].mode, plan[k].grp, plan[k].ifa, plan[k].typed, plan[k].res);
			end
		end

		phase_em = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hE000_0010, 32'hE000_0011,
			32'hEF7F_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hE080_0000};
		phase_lt = '{4'd0, 4'd15, 4'd4, 4'd5, 4'd1, 4'd0, 4'd15, 4'd0};
		phase_em[5] = $urandom;
		phase_lt[5] = 4'($urandom_range(15));

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			cfg_write(mgmt_pkg::REG_EMPTY_MARKER, phase_em[ph]);
			cfg_write(mgmt_pkg::REG_LINK_TYPE, mgmt_pkg::CFG_DATA_W'(phase_lt[ph]));
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				1: begin
					send_idle_pct = 63;
					recv_idle_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_idle_pct = 63;
				end
				default: begin
					send_idle_pct = 29;
					recv_idle_pct = 29;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 0 && n == 60)
					hold_go = 1;
				if (ph == 2 && n == 100) begin
					s_tvalid <= 1'b0;
					do @(posedge clk); while (result_q.size() != 0);
				end
				roll = $urandom_range(99);
				if (roll < 42)
					md = mgmt_pkg::MODE_JOIN;
				else if (roll < 72)
					md = mgmt_pkg::MODE_LEAVE;
				else if (roll < 96)
					md = mgmt_pkg::MODE_LOOKUP;
				else
					md = mgmt_pkg::MODE_CLEAR;
				issue(md, pick_group(), pick_iface(), 1'b0, '0);
			end
		end

		settle();
		repeat (4) @(posedge clk);
		if (result_q.size() != 0) begin
			$display("%0d expected result words never arrived", result_q.size());
			mismatches += result_q.size();
		end
		$display("run covered %0d request words: directed table and %0d randomized phases",
			accepted, PHASES);
		$display("across empty markers, link types and stall patterns; %0d results checked",
			checked);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
